FILE: rtl/tile_sprite_pixel_blitter_top_macros.svh
// ----------------------------------------------------------------------------
// Tile sprite pixel blitter assertion macros
// Shorthand for clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TILE_SPRITE_PIXEL_BLITTER_TOP_MACROS_SVH
`define TILE_SPRITE_PIXEL_BLITTER_TOP_MACROS_SVH

// same-cycle implication
`define TSPB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tspb_pkg.sv
// ----------------------------------------------------------------------------
// Tile sprite pixel blitter package
// Shared widths, register codes, reset values, palette table and prep struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tspb_pkg;

  localparam int unsigned TilePix   = 64;   // pixels per 8x8 tile
  localparam int unsigned TileSide  = 8;
  localparam int unsigned PixIdxW   = 6;
  localparam int unsigned SideW     = 3;
  localparam int unsigned ShadeW    = 2;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned PosW      = 9;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ColorW    = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned PalW      = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH    = 2'd0,
    CFG_SCREEN_HEIGHT   = 2'd1,
    CFG_PALETTE_STYLE   = 2'd2,
    CFG_SPRITES_ENABLED = 2'd3
  } cfg_reg_e;

  typedef enum logic [PalW-1:0] {
    PAL_GREEN   = 2'd0,
    PAL_GRAY    = 2'd1,
    PAL_VIBRANT = 2'd2
  } palette_e;

  localparam logic [CoordW-1:0] WidthRst   = 8'd160;
  localparam logic [CoordW-1:0] HeightRst  = 8'd144;
  localparam logic [PalW-1:0]   PaletteRst = PAL_GREEN;
  localparam logic              SpritesRst = 1'b1;

  localparam logic [3:0][ColorW-1:0] PalGreen = {
    32'hFF0F380F, 32'hFF306230, 32'hFF8BAC0F, 32'hFF9BBC0F
  };
  localparam logic [3:0][ColorW-1:0] PalGray = {
    32'hFF000000, 32'hFF555555, 32'hFFAAAAAA, 32'hFFFFFFFF
  };
  localparam logic [3:0][ColorW-1:0] PalVibrant = {
    32'hFF081820, 32'hFF346856, 32'hFF88C070, 32'hFFE0F8D0
  };

  // per-pixel shades in raster order after mirroring, plus draw mask
  typedef struct packed {
    logic [TilePix-1:0][ShadeW-1:0] shade;
    logic [TilePix-1:0]             mask;
  } tile_prep_t;

  // unused style code falls back to the green LCD set
  function automatic logic [ColorW-1:0] palette_color(logic [PalW-1:0] sel,
                                                      logic [ShadeW-1:0] shade);
    logic [ColorW-1:0] c;
    unique case (sel)
      PAL_GRAY:    c = PalGray[shade];
      PAL_VIBRANT: c = PalVibrant[shade];
      default:     c = PalGreen[shade];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tspb_tile_prep.sv
// ----------------------------------------------------------------------------
// Tile sprite pixel blitter tile prep
// Reorders tile shades for mirroring and builds the per-pixel draw mask
// (clipping, transparency and sprite gating) for an incoming beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tspb_tile_prep
  import tspb_pkg::*;
(
  input  wire logic [63:0]         tile_rows_top_i,
  input  wire logic [63:0]         tile_rows_bottom_i,
  input  wire logic [PosW-1:0]     pos_x_i,
  input  wire logic [PosW-1:0]     pos_y_i,
  input  wire logic                mirror_x_i,
  input  wire logic                mirror_y_i,
  input  wire logic                transparent_i,
  input  wire logic [CoordW-1:0]   screen_width_i,
  input  wire logic [CoordW-1:0]   screen_height_i,
  input  wire logic                sprites_enabled_i,
  output tile_prep_t               prep_o
);

  logic [2*TilePix-1:0] tile_bits;
  logic [TileSide-1:0]  row_vis;
  logic [TileSide-1:0]  col_vis;

  assign tile_bits = {tile_rows_bottom_i, tile_rows_top_i};

  // sum is 10-bit signed: bit 9 set means off the top/left edge
  always_comb begin
    logic [PosW:0] ysum;
    logic [PosW:0] xsum;
    ysum = '0;
    xsum = '0;
    for (int unsigned k = 0; k < TileSide; k++) begin
      ysum = {pos_y_i[PosW-1], pos_y_i} + (PosW+1)'(k);
      xsum = {pos_x_i[PosW-1], pos_x_i} + (PosW+1)'(k);
      row_vis[k] = !ysum[PosW] && (ysum[PosW-1:0] < {1'b0, screen_height_i});
      col_vis[k] = !xsum[PosW] && (xsum[PosW-1:0] < {1'b0, screen_width_i});
    end
  end

  always_comb begin
    logic [SideW-1:0]   ty;
    logic [SideW-1:0]   tx;
    logic [PixIdxW-1:0] src;
    logic               gated;
    gated = transparent_i && !sprites_enabled_i;
    prep_o = '0;
    for (int unsigned p = 0; p < TilePix; p++) begin
      ty  = SideW'(p >> SideW);
      tx  = SideW'(p);
      src = {ty ^ {SideW{mirror_y_i}}, tx ^ {SideW{mirror_x_i}}};
      prep_o.shade[p] = tile_bits[ShadeW*src +: ShadeW];
      prep_o.mask[p]  = row_vis[ty] && col_vis[tx] && !gated &&
                        !(transparent_i && (prep_o.shade[p] == '0));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tile_sprite_pixel_blitter_top.sv
// ----------------------------------------------------------------------------
// Tile sprite pixel blitter
// Turns one 8x8 2bpp tile into clipped framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tile per beat: shades,
//   signed position, mirror flags and the transparent flag. Output channel
//   (out_valid_o / out_stall_i) carries one pixel write per beat, with last
//   set on the final write of a tile. A tile with nothing visible makes no
//   output beats.
//   The tile is registered with a 64-bit draw mask; a scan counter walks the
//   64 pixel slots one per cycle (waiting at a visible slot while the output
//   is stalled); each visible slot is turned into x, y, address (one 8x8
//   multiply) and palette color into the output register. Slots are scanned
//   in order, so the first write of a tile is its lowest visible slot.
//   Writes issue one per cycle while the output is not stalled; a tile
//   occupies the scanner until its last visible slot is issued. The next tile is
//   taken in the cycle the previous tile's last write is issued.
//   Output stall holds the output register; the scan runs past blank slots
//   and waits at the next visible one. Input stall rises while a tile still
//   has writes to issue.
//   Reset clears the scanner and output valid and loads the register
//   defaults: 160 x 144 screen, green palette, sprites enabled.
//   Config writes are taken at any time but must only change while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tile_sprite_pixel_blitter_top_macros.svh"

module tile_sprite_pixel_blitter_top
  import tspb_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // config
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // tile in
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [63:0]         tile_rows_top_i,
  input  wire logic [63:0]         tile_rows_bottom_i,
  input  wire logic [PosW-1:0]     pos_x_i,
  input  wire logic [PosW-1:0]     pos_y_i,
  input  wire logic                mirror_x_i,
  input  wire logic                mirror_y_i,
  input  wire logic                transparent_i,
  // pixel out
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic [CoordW-1:0]   pix_x_o,
  output      logic [CoordW-1:0]   pix_y_o,
  output      logic [AddrW-1:0]    fb_address_o,
  output      logic [ShadeW-1:0]   shade_o,
  output      logic [ColorW-1:0]   color_o,
  output      logic                last_o
);

  // config registers
  logic [CoordW-1:0] screen_width_q, screen_height_q;
  logic [PalW-1:0]   palette_q;
  logic              sprites_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= WidthRst;
      screen_height_q <= HeightRst;
      palette_q       <= PaletteRst;
      sprites_en_q    <= SpritesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCREEN_WIDTH:    screen_width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT:   screen_height_q <= cfg_data_i;
        CFG_PALETTE_STYLE:   palette_q       <= cfg_data_i[PalW-1:0];
        CFG_SPRITES_ENABLED: sprites_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // tile prep
  tile_prep_t prep;

  tspb_tile_prep u_prep (
    .tile_rows_top_i    (tile_rows_top_i),
    .tile_rows_bottom_i (tile_rows_bottom_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .mirror_x_i         (mirror_x_i),
    .mirror_y_i         (mirror_y_i),
    .transparent_i      (transparent_i),
    .screen_width_i     (screen_width_q),
    .screen_height_i    (screen_height_q),
    .sprites_enabled_i  (sprites_en_q),
    .prep_o             (prep)
  );

  // scanner state
  logic [TilePix-1:0][ShadeW-1:0] shade_q;
  logic [TilePix-1:0]             mask_q, mask_d, mask_rest;
  logic [PixIdxW-1:0]             idx_q, idx_d;
  logic [CoordW-1:0]              org_x_q, org_y_q;

  logic load, busy, cur_vis, out_free, emit, step, finishing;

  assign busy      = (mask_q != '0);
  assign cur_vis   = mask_q[idx_q];
  assign out_free  = !out_valid_o || !out_stall_i;
  assign emit      = cur_vis && out_free;
  assign step      = busy && (!cur_vis || out_free);
  assign mask_rest = mask_q & ~(TilePix'(1) << idx_q);
  assign finishing = emit && (mask_rest == '0);

  assign in_stall_o = busy && !finishing;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    mask_d = mask_q;
    idx_d  = idx_q;
    if (load) begin
      mask_d = prep.mask;
      idx_d  = '0;
    end else begin
      if (emit) begin
        mask_d = mask_rest;
      end
      if (step) begin
        idx_d = idx_q + PixIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      idx_q  <= '0;
    end else begin
      mask_q <= mask_d;
      idx_q  <= idx_d;
    end
  end

  // only the low byte of the position matters: visible coords are 0..254
  always_ff @(posedge clk_i) begin
    if (load) begin
      shade_q <= prep.shade;
      org_x_q <= pos_x_i[CoordW-1:0];
      org_y_q <= pos_y_i[CoordW-1:0];
    end
  end

  // pixel result
  logic [CoordW-1:0] pix_x_d, pix_y_d;
  logic [AddrW-1:0]  addr_d;

  assign pix_x_d = org_x_q + CoordW'(idx_q[SideW-1:0]);
  assign pix_y_d = org_y_q + CoordW'(idx_q[PixIdxW-1:SideW]);
  assign addr_d  = AddrW'(pix_y_d) * AddrW'(screen_width_q) + AddrW'(pix_x_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      pix_x_o      <= pix_x_d;
      pix_y_o      <= pix_y_d;
      fb_address_o <= addr_d;
      shade_o      <= shade_q[idx_q];
      color_o      <= palette_color(palette_q, shade_q[idx_q]);
      last_o       <= (mask_rest == '0);
    end
  end

  // checks
  `TSPB_ASSERT_IMP(a_addr_match, out_valid_o,
    fb_address_o == AddrW'(AddrW'(pix_y_o) * AddrW'(screen_width_q) + AddrW'(pix_x_o)),
    "fb_address does not match pixel coordinates")
  `TSPB_ASSERT_IMP(a_in_screen, out_valid_o,
    (pix_x_o < screen_width_q) && (pix_y_o < screen_height_q),
    "pixel write outside screen")
  `TSPB_ASSERT_NXT(a_load_restarts, load, idx_q == '0,
    "scan did not restart at pixel 0 after tile load")

endmodule

`default_nettype wire

FILE: tb/tile_blitter_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile blitter pixel write checker
// Tracks the register file, turns every accepted tile beat into the expected
// framebuffer writes and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------

module tile_blitter_write_checker
  import tspb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [63:0]         tile_rows_top_i,
  input  logic [63:0]         tile_rows_bottom_i,
  input  logic [PosW-1:0]     pos_x_i,
  input  logic [PosW-1:0]     pos_y_i,
  input  logic                mirror_x_i,
  input  logic                mirror_y_i,
  input  logic                transparent_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [CoordW-1:0]   pix_x_i,
  input  logic [CoordW-1:0]   pix_y_i,
  input  logic [AddrW-1:0]    fb_address_i,
  input  logic [ShadeW-1:0]   shade_i,
  input  logic [ColorW-1:0]   color_i,
  input  logic                last_i,
  output int                  mismatch_count_o,
  output int                  writes_pending_o
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [AddrW-1:0]  addr;
    logic [ShadeW-1:0] shade;
    logic [ColorW-1:0] color;
    logic              last;
  } pix_write_t;

  logic [CoordW-1:0] scr_w;
  logic [CoordW-1:0] scr_h;
  logic [PalW-1:0]   pal_style;
  logic              sprites_on;

  pix_write_t pending_writes[$];
  int         fail_tally = 0;
  int         pending_cnt = 0;

  assign mismatch_count_o = fail_tally;
  assign writes_pending_o = pending_cnt;

  function automatic logic [ColorW-1:0] shade_color(logic [PalW-1:0] style,
                                                    logic [ShadeW-1:0] sh);
    logic [ColorW-1:0] c;
    case (palette_e'(style))
      PAL_GRAY: begin
        case (sh)
          2'd0: c = 32'hFFFFFFFF;
          2'd1: c = 32'hFFAAAAAA;
          2'd2: c = 32'hFF555555;
          default: c = 32'hFF000000;
        endcase
      end
      PAL_VIBRANT: begin
        case (sh)
          2'd0: c = 32'hFFE0F8D0;
          2'd1: c = 32'hFF88C070;
          2'd2: c = 32'hFF346856;
          default: c = 32'hFF081820;
        endcase
      end
      // style 3 is unused and shows the green set
      default: begin
        case (sh)
          2'd0: c = 32'hFF9BBC0F;
          2'd1: c = 32'hFF8BAC0F;
          2'd2: c = 32'hFF306230;
          default: c = 32'hFF0F380F;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic void predict_tile_writes(logic [63:0] top, logic [63:0] bottom,
                                              logic [PosW-1:0] pos_x,
                                              logic [PosW-1:0] pos_y,
                                              logic mx, logic my, logic transp);
    int          px;
    int          py;
    int          x;
    int          y;
    int          sx;
    int          sy;
    int          idx;
    int          ty;
    int          tx;
    logic [63:0] word;
    logic [1:0]  sh;
    pix_write_t  w;
    pix_write_t  tile_writes[$];
    px = pos_x;
    py = pos_y;
    if (pos_x[PosW-1]) px -= 512;
    if (pos_y[PosW-1]) py -= 512;
    if (transp && !sprites_on) return;
    for (ty = 0; ty < 8; ty++) begin
      y = py + ty;
      if (y < 0 || y >= int'(scr_h)) continue;
      sy = my ? 7 - ty : ty;
      for (tx = 0; tx < 8; tx++) begin
        x = px + tx;
        if (x < 0 || x >= int'(scr_w)) continue;
        sx = mx ? 7 - tx : tx;
        idx = sy * 8 + sx;
        word = (idx < 32) ? top : bottom;
        sh = word[(idx % 32) * 2 +: 2];
        if (transp && sh == 2'd0) continue;
        w.x = x[CoordW-1:0];
        w.y = y[CoordW-1:0];
        w.addr = AddrW'(y * int'(scr_w) + x);
        w.shade = sh;
        w.color = shade_color(pal_style, sh);
        w.last = 1'b0;
        tile_writes.push_back(w);
      end
    end
    if (tile_writes.size() > 0) begin
      w = tile_writes.pop_back();
      w.last = 1'b1;
      tile_writes.push_back(w);
    end
    foreach (tile_writes[i]) pending_writes.push_back(tile_writes[i]);
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      fail_tally++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_write_t exp_w;
    if (!rst_ni) begin
      scr_w = WidthRst;
      scr_h = HeightRst;
      pal_style = PaletteRst;
      sprites_on = SpritesRst;
      pending_writes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SCREEN_WIDTH:    scr_w = cfg_data_i;
          CFG_SCREEN_HEIGHT:   scr_h = cfg_data_i;
          CFG_PALETTE_STYLE:   pal_style = cfg_data_i[PalW-1:0];
          CFG_SPRITES_ENABLED: sprites_on = cfg_data_i[0];
          default: ;
        endcase
      end
      // output first: a write leaving on the same edge belongs to an older tile
      if (out_valid_i && !out_stall_i) begin
        if (pending_writes.size() == 0) begin
          $error("pixel write with none expected: x=%0d y=%0d", pix_x_i, pix_y_i);
          fail_tally++;
        end else begin
          exp_w = pending_writes.pop_front();
          check_field("pix_x", exp_w.x, pix_x_i);
          check_field("pix_y", exp_w.y, pix_y_i);
          check_field("fb_address", exp_w.addr, fb_address_i);
          check_field("shade", exp_w.shade, shade_i);
          check_field("color", exp_w.color, color_i);
          check_field("last", exp_w.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_tile_writes(tile_rows_top_i, tile_rows_bottom_i, pos_x_i, pos_y_i,
                            mirror_x_i, mirror_y_i, transparent_i);
      end
    end
    pending_cnt = pending_writes.size();
  end

endmodule

FILE: tb/tb_tile_sprite_pixel_blitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile sprite pixel blitter testbench
// Directed tiles at the clipping edges, mirror and transparency corners and
// odd register settings, then three random phases with sender gaps, output
// stalls and one long output hold-off. The checker predicts every write.
// ----------------------------------------------------------------------------

module tb_tile_sprite_pixel_blitter_top;
  import tspb_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [63:0]     top;
    logic [63:0]     bottom;
    logic [PosW-1:0] px;
    logic [PosW-1:0] py;
    logic            mx;
    logic            my;
    logic            transp;
  } tile_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [63:0]         tile_rows_top_i;
  logic [63:0]         tile_rows_bottom_i;
  logic [PosW-1:0]     pos_x_i;
  logic [PosW-1:0]     pos_y_i;
  logic                mirror_x_i;
  logic                mirror_y_i;
  logic                transparent_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CoordW-1:0]   pix_x_o;
  logic [CoordW-1:0]   pix_y_o;
  logic [AddrW-1:0]    fb_address_o;
  logic [ShadeW-1:0]   shade_o;
  logic [ColorW-1:0]   color_o;
  logic                last_o;

  int   write_errors;
  int   writes_left;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cur_w = 160;
  int   cur_h = 144;
  int   cycle_count = 0;
  logic pressure_go = 1'b0;
  logic hold_output = 1'b0;

  always #10 clk_i = ~clk_i;

  tile_sprite_pixel_blitter_top DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .tile_rows_top_i    (tile_rows_top_i),
    .tile_rows_bottom_i (tile_rows_bottom_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .mirror_x_i         (mirror_x_i),
    .mirror_y_i         (mirror_y_i),
    .transparent_i      (transparent_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pix_x_o            (pix_x_o),
    .pix_y_o            (pix_y_o),
    .fb_address_o       (fb_address_o),
    .shade_o            (shade_o),
    .color_o            (color_o),
    .last_o             (last_o)
  );

  tile_blitter_write_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .tile_rows_top_i    (tile_rows_top_i),
    .tile_rows_bottom_i (tile_rows_bottom_i),
    .pos_x_i            (pos_x_i),
    .pos_y_i            (pos_y_i),
    .mirror_x_i         (mirror_x_i),
    .mirror_y_i         (mirror_y_i),
    .transparent_i      (transparent_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pix_x_i            (pix_x_o),
    .pix_y_i            (pix_y_o),
    .fb_address_i       (fb_address_o),
    .shade_i            (shade_o),
    .color_i            (color_o),
    .last_i             (last_o),
    .mismatch_count_o   (write_errors),
    .writes_pending_o   (writes_left)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_tile_sprite_pixel_blitter_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_output || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long output hold-off so the scanner backs up into the input channel
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_output <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  function automatic tile_item_t make_tile(logic [63:0] top, logic [63:0] bottom,
                                           int x, int y, int mx, int my,
                                           int transp);
    tile_item_t t;
    t.top = top;
    t.bottom = bottom;
    t.px = PosW'(x);
    t.py = PosW'(y);
    t.mx = 1'(mx);
    t.my = 1'(my);
    t.transp = 1'(transp);
    return t;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PosW-1:0] pick_pos(int span);
    if ($urandom_range(0, 6) == 0) return PosW'($urandom);
    return PosW'(int'($urandom_range(0, span + 8)) - 8);
  endfunction

  function automatic logic [63:0] pick_shades();
    case ($urandom_range(0, 3))
      0: return rand64() & rand64() & rand64();  // mostly shade 0
      1: return rand64() | rand64();
      default: return rand64();
    endcase
  endfunction

  function automatic tile_item_t random_tile();
    tile_item_t t;
    t.top = pick_shades();
    t.bottom = pick_shades();
    t.px = pick_pos(cur_w);
    t.py = pick_pos(cur_h);
    t.mx = 1'($urandom_range(0, 1));
    t.my = 1'($urandom_range(0, 1));
    t.transp = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic offer_tile(input tile_item_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    tile_rows_top_i <= t.top;
    tile_rows_bottom_i <= t.bottom;
    pos_x_i <= t.px;
    pos_y_i <= t.py;
    mirror_x_i <= t.mx;
    mirror_y_i <= t.my;
    transparent_i <= t.transp;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid and wait out every expected write plus the scan of blank tiles
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (writes_left != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_screen(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h,
                            logic [CfgDataW-1:0] pal, logic [CfgDataW-1:0] spr);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_SCREEN_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_index_i <= CFG_SCREEN_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_index_i <= CFG_PALETTE_STYLE;
    cfg_data_i <= pal;
    @(posedge clk_i);
    cfg_index_i <= CFG_SPRITES_ENABLED;
    cfg_data_i <= spr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic random_phase(int n_items, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) offer_tile(random_tile());
    drain();
  endtask

  initial begin
    logic [63:0] ramp_top;
    logic [63:0] ramp_bot;
    ramp_top = 64'h0123456789ABCDEF;
    ramp_bot = 64'hFEDCBA9876543210;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_SCREEN_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    tile_rows_top_i = '0;
    tile_rows_bottom_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    mirror_x_i = 1'b0;
    mirror_y_i = 1'b0;
    transparent_i = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset defaults: 160 x 144, green, sprites on
    recv_idle_pct = 25;
    offer_tile(make_tile('0, '0, 0, 0, 0, 0, 0));
    offer_tile(make_tile('1, '1, 0, 0, 0, 0, 0));
    offer_tile(make_tile({32{2'b10}}, {32{2'b01}}, 152, 136, 0, 0, 0));
    offer_tile(make_tile(rand64(), rand64(), 153, 137, 0, 0, 0));
    offer_tile(make_tile(rand64(), rand64(), -256, -256, 0, 0, 0));
    offer_tile(make_tile(rand64(), rand64(), 255, 255, 1, 1, 0));
    offer_tile(make_tile(rand64(), rand64(), -7, -7, 0, 0, 0));
    offer_tile(make_tile(ramp_top, ramp_bot, 40, 30, 1, 0, 0));
    offer_tile(make_tile(ramp_top, ramp_bot, 40, 30, 0, 1, 0));
    offer_tile(make_tile(ramp_top, ramp_bot, 40, 30, 1, 1, 0));
    offer_tile(make_tile(rand64(), rand64(), 10, 10, 0, 0, 1));
    offer_tile(make_tile('0, '0, 10, 10, 0, 0, 1));
    drain();

    // widest screen, sprites off
    set_screen(8'd255, 8'd255, 8'h01, 8'h00);
    offer_tile(make_tile(rand64(), rand64(), 0, 0, 0, 0, 1));
    offer_tile(make_tile(rand64(), rand64(), 247, 247, 0, 0, 0));
    offer_tile(make_tile(rand64(), rand64(), -3, 250, 1, 1, 0));
    drain();

    // one-pixel screen; upper data bits must be dropped
    set_screen(8'd1, 8'd1, 8'hFE, 8'h03);
    offer_tile(make_tile(rand64() | rand64(), rand64(), 0, 0, 0, 0, 1));
    offer_tile(make_tile('1, '1, -7, 0, 0, 0, 0));
    drain();

    // zero width, then zero height clip everything; style 3 falls back to green
    set_screen(8'd0, 8'd144, 8'h07, 8'h01);
    offer_tile(make_tile(rand64(), rand64(), 0, 0, 0, 0, 0));
    drain();
    set_screen(8'd10, 8'd0, 8'h03, 8'h01);
    offer_tile(make_tile(rand64(), rand64(), 0, 0, 0, 0, 0));
    drain();
    set_screen(8'd20, 8'd20, 8'h03, 8'h00);
    offer_tile(make_tile(ramp_top, ramp_bot, 4, 4, 0, 0, 0));
    offer_tile(make_tile('1, '1, 4, 4, 0, 0, 1));
    drain();

    set_screen(8'($urandom_range(8, 255)), 8'($urandom_range(8, 255)),
               8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)));
    random_phase(84, 38, 50);

    set_screen(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
               8'($urandom_range(0, 3)), 8'($urandom_range(0, 1)));
    random_phase(84, 50, 38);

    set_screen(8'd255, 8'd255, 8'h02, 8'h01);
    pressure_go = 1'b1;
    random_phase(84, 0, 0);

    if (write_errors == 0 && writes_left == 0) begin
      $display("tb_tile_sprite_pixel_blitter_top: done, clean");
    end else begin
      $display("tb_tile_sprite_pixel_blitter_top: done, errors");
    end
    $finish;
  end

endmodule
